[hdl/pau_pkg.sv]
// shared types and constants for the pareto archive update block
`timescale 1ns / 1ps
`default_nettype none
package pau_pkg;

  localparam int ARCHIVE_DEPTH = 64;
  localparam int OBJ_W         = 32;
  localparam int IN_W          = 32;
  localparam int RES_W         = 7;
  localparam int IDX_W         = $clog2(ARCHIVE_DEPTH);
  localparam int CNT_W         = $clog2(ARCHIVE_DEPTH + 1);

  typedef struct packed {
    logic [OBJ_W-1:0] price;
    logic [OBJ_W-1:0] mileage;
    logic [OBJ_W-1:0] displacement;
  } point_t;

  typedef enum logic [1:0] {
    ST_INSERTED = 2'd0,
    ST_REJECTED = 2'd1,
    ST_FULL     = 2'd2
  } status_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_READ,
    S_EVAL,
    S_FINISH
  } state_t;

  typedef struct packed {
    logic             we;
    logic [IDX_W-1:0] waddr;
    point_t           wdata;
    logic             re;
    logic [IDX_W-1:0] raddr;
  } mem_req_t;

  typedef struct packed {
    logic entry_dom_pt;
    logic pt_dom_entry;
  } dom_t;

endpackage
`default_nettype wire

[hdl/pau_store.sv]
// archive entry memory, one write and one registered read per cycle
`timescale 1ns / 1ps
`default_nettype none
module pau_store (
  input  wire logic              clk,
  input  wire pau_pkg::mem_req_t req,
  output pau_pkg::point_t        rdata
);

  pau_pkg::point_t mem [pau_pkg::ARCHIVE_DEPTH];
  pau_pkg::point_t rdata_r;

  always_ff @(posedge clk) begin
    if (req.we) begin
      mem[req.waddr] <= req.wdata;
    end
    if (req.re) begin
      rdata_r <= mem[req.raddr];
    end
  end

  assign rdata = rdata_r;

endmodule
`default_nettype wire

[hdl/pau_dom.sv]
// dominance compare between a stored entry and the new point
`timescale 1ns / 1ps
`default_nettype none
module pau_dom (
  input  wire pau_pkg::point_t entry,
  input  wire pau_pkg::point_t pt,
  output pau_pkg::dom_t        dom
);

  logic [2:0] e_gt;
  logic [2:0] e_lt;

  always_comb begin
    e_gt[0] = entry.price > pt.price;
    e_lt[0] = entry.price < pt.price;
    e_gt[1] = entry.mileage > pt.mileage;
    e_lt[1] = entry.mileage < pt.mileage;
    e_gt[2] = entry.displacement > pt.displacement;
    e_lt[2] = entry.displacement < pt.displacement;
    // equal points dominate neither way
    dom.entry_dom_pt = (|e_gt) && !(|e_lt);
    dom.pt_dom_entry = (|e_lt) && !(|e_gt);
  end

endmodule
`default_nettype wire

[hdl/pau_ctrl.sv]
// walk sequencer: read, compare, compact and append
`timescale 1ns / 1ps
`default_nettype none
module pau_ctrl (
  input  wire logic                    clk,
  input  wire logic                    rst_n,
  input  wire logic                    start,
  output logic                         busy,
  input  wire pau_pkg::point_t         in_pt,
  output pau_pkg::point_t              pt,
  input  wire pau_pkg::point_t         rdata,
  input  wire pau_pkg::dom_t           dom,
  output pau_pkg::mem_req_t            req,
  output logic                         out_valid,
  output logic [1:0]                   out_status,
  output logic [pau_pkg::RES_W-1:0]    out_removed,
  output logic [pau_pkg::RES_W-1:0]    out_count_after
);

  localparam logic [pau_pkg::CNT_W-1:0] DEPTH_C = pau_pkg::CNT_W'(pau_pkg::ARCHIVE_DEPTH);

  pau_pkg::state_t          state_r, state_nxt;
  pau_pkg::point_t          pt_r, pt_nxt;
  logic [pau_pkg::CNT_W-1:0] cnt_r, cnt_nxt;
  logic [pau_pkg::CNT_W-1:0] rd_r, rd_nxt;
  logic [pau_pkg::CNT_W-1:0] wr_r, wr_nxt;
  logic [pau_pkg::CNT_W-1:0] removed_r, removed_nxt;
  logic                      rej_r, rej_nxt;
  logic                      valid_r, valid_nxt;
  pau_pkg::status_t          status_r, status_nxt;
  logic [pau_pkg::CNT_W-1:0] res_removed_r, res_removed_nxt;
  logic [pau_pkg::CNT_W-1:0] res_count_r, res_count_nxt;
  logic [pau_pkg::CNT_W-1:0] kept;

  assign kept = cnt_r - removed_r;

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      pau_pkg::S_IDLE: begin
        if (start) state_nxt = pau_pkg::S_READ;
      end
      pau_pkg::S_READ: begin
        state_nxt = (rd_r < cnt_r) ? pau_pkg::S_EVAL : pau_pkg::S_FINISH;
      end
      pau_pkg::S_EVAL: begin
        // rejection with nothing removed leaves the tail in place
        if (!rej_r && dom.entry_dom_pt && removed_r == '0) state_nxt = pau_pkg::S_FINISH;
        else state_nxt = pau_pkg::S_READ;
      end
      pau_pkg::S_FINISH: state_nxt = pau_pkg::S_IDLE;
      default: state_nxt = pau_pkg::S_IDLE;
    endcase
  end

  // datapath and memory requests
  always_comb begin
    pt_nxt          = pt_r;
    cnt_nxt         = cnt_r;
    rd_nxt          = rd_r;
    wr_nxt          = wr_r;
    removed_nxt     = removed_r;
    rej_nxt         = rej_r;
    valid_nxt       = 1'b0;
    status_nxt      = status_r;
    res_removed_nxt = res_removed_r;
    res_count_nxt   = res_count_r;
    req             = '0;
    case (state_r)
      pau_pkg::S_IDLE: begin
        if (start) begin
          pt_nxt      = in_pt;
          rd_nxt      = '0;
          wr_nxt      = '0;
          removed_nxt = '0;
          rej_nxt     = 1'b0;
        end
      end
      pau_pkg::S_READ: begin
        if (rd_r < cnt_r) begin
          req.re    = 1'b1;
          req.raddr = rd_r[pau_pkg::IDX_W-1:0];
        end
      end
      pau_pkg::S_EVAL: begin
        if (!rej_r && dom.pt_dom_entry && !dom.entry_dom_pt) begin
          removed_nxt = removed_r + 1'b1;
          rd_nxt      = rd_r + 1'b1;
        end else if (!rej_r && dom.entry_dom_pt && removed_r == '0) begin
          rej_nxt = 1'b1;
        end else begin
          // keep the entry, shifted down over the removed ones
          if (dom.entry_dom_pt) rej_nxt = 1'b1;
          req.we    = (wr_r != rd_r);
          req.waddr = wr_r[pau_pkg::IDX_W-1:0];
          req.wdata = rdata;
          wr_nxt    = wr_r + 1'b1;
          rd_nxt    = rd_r + 1'b1;
        end
      end
      pau_pkg::S_FINISH: begin
        valid_nxt       = 1'b1;
        res_removed_nxt = removed_r;
        if (rej_r) begin
          status_nxt = pau_pkg::ST_REJECTED;
          cnt_nxt    = kept;
        end else if (kept < DEPTH_C) begin
          status_nxt = pau_pkg::ST_INSERTED;
          req.we     = 1'b1;
          req.waddr  = kept[pau_pkg::IDX_W-1:0];
          req.wdata  = pt_r;
          cnt_nxt    = kept + 1'b1;
        end else begin
          status_nxt = pau_pkg::ST_FULL;
          cnt_nxt    = kept;
        end
        res_count_nxt = cnt_nxt;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= pau_pkg::S_IDLE;
      cnt_r   <= '0;
      valid_r <= 1'b0;
      rej_r   <= 1'b0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
      valid_r <= valid_nxt;
      rej_r   <= rej_nxt;
    end
    pt_r          <= pt_nxt;
    rd_r          <= rd_nxt;
    wr_r          <= wr_nxt;
    removed_r     <= removed_nxt;
    status_r      <= status_nxt;
    res_removed_r <= res_removed_nxt;
    res_count_r   <= res_count_nxt;
  end

  assign busy            = (state_r != pau_pkg::S_IDLE);
  assign pt              = pt_r;
  assign out_valid       = valid_r;
  assign out_status      = status_r;
  assign out_removed     = pau_pkg::RES_W'(res_removed_r);
  assign out_count_after = pau_pkg::RES_W'(res_count_r);

endmodule
`default_nettype wire

[hdl/pareto_archive_update_core.sv]
// top level of the pareto archive update block
`timescale 1ns / 1ps
`default_nettype none
// Keeps an ordered archive of up to 64 mutually non-dominated three-objective
// points (larger is better). A point is taken when start is high and busy is
// low; busy stays high for the walk. Each stored entry takes a read state for
// the synchronous memory read and then an eval state for the compare and
// compacting write; the walk ends early when an entry dominates the point and
// nothing was removed before it. The single result appears in the first cycle
// with busy low, with out_valid high for exactly one cycle; it cannot be
// stalled. The next point can be taken at the end of that cycle, so the block
// takes no new point while a walk is in progress.
// Reads always run ahead of compacting writes, so no forwarding is needed.
module pareto_archive_update_core (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire logic                       start,
  output logic                            busy,
  input  wire logic [pau_pkg::IN_W-1:0]   in_price,
  input  wire logic [pau_pkg::IN_W-1:0]   in_mileage,
  input  wire logic [pau_pkg::IN_W-1:0]   in_displacement,
  output logic                            out_valid,
  output logic [1:0]                      out_status,
  output logic [pau_pkg::RES_W-1:0]       out_removed,
  output logic [pau_pkg::RES_W-1:0]       out_count_after
);

  pau_pkg::point_t   in_pt;
  pau_pkg::point_t   pt;
  pau_pkg::point_t   rdata;
  pau_pkg::dom_t     dom;
  pau_pkg::mem_req_t req;

  assign in_pt.price        = in_price[pau_pkg::OBJ_W-1:0];
  assign in_pt.mileage      = in_mileage[pau_pkg::OBJ_W-1:0];
  assign in_pt.displacement = in_displacement[pau_pkg::OBJ_W-1:0];

  pau_ctrl u_ctrl (
    .clk             (clk),
    .rst_n           (rst_n),
    .start           (start),
    .busy            (busy),
    .in_pt           (in_pt),
    .pt              (pt),
    .rdata           (rdata),
    .dom             (dom),
    .req             (req),
    .out_valid       (out_valid),
    .out_status      (out_status),
    .out_removed     (out_removed),
    .out_count_after (out_count_after)
  );

  pau_store u_store (
    .clk   (clk),
    .req   (req),
    .rdata (rdata)
  );

  pau_dom u_dom (
    .entry (rdata),
    .pt    (pt),
    .dom   (dom)
  );

  // a result beat always closes a walk
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(busy) && !busy)
    else $error("result beat without a finished walk");

  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_count_after <= pau_pkg::RES_W'(pau_pkg::ARCHIVE_DEPTH))
    else $error("archive count beyond depth");

  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status == pau_pkg::ST_FULL |->
      out_count_after == pau_pkg::RES_W'(pau_pkg::ARCHIVE_DEPTH) && out_removed == '0)
    else $error("full status with room in the archive");

  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status == pau_pkg::ST_INSERTED |-> out_count_after != '0)
    else $error("insert left the archive empty");

endmodule
`default_nettype wire
